/* design/mtsvm_pkg.sv */
// Shared constants, operation and voice-state codes for the one-shot sample voice mixer.
// No dependencies; imported by the top level.
package mtsvm_pkg;

    // Default sizes for the top-level parameters.
    localparam int NUM_SLOTS_DEF   = 10;
    localparam int SLOT_DEPTH_DEF  = 16384;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths.
    localparam int OP_W   = 3;
    localparam int SLOT_W = 4;
    localparam int BYTE_W = 8;
    localparam int VEL_W  = 7;
    localparam int MIX_W  = 20;

    // Operation codes carried by each input beat.
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_MIDI    = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
    localparam logic [OP_W-1:0] OP_CONFIG  = 3'd3;
    localparam logic [OP_W-1:0] OP_TRIGGER = 3'd4;

    // Voice states as stored in the slot memory.
    localparam logic [1:0] VS_STOPPED   = 2'd0;
    localparam logic [1:0] VS_TRIGGERED = 2'd1;
    localparam logic [1:0] VS_PLAYING   = 2'd2;

    localparam logic [3:0]        MIDI_NOTE_ON = 4'h9;
    localparam logic [BYTE_W-1:0] NOTE_NONE    = 8'd128;
    localparam logic [VEL_W-1:0]  VEL_RESET    = 7'd102;
    localparam logic [VEL_W-1:0]  VEL_MAX      = 7'd127;

    // Trigger note of each slot after reset: a basic drum kit, the rest unmapped.
    function automatic logic [BYTE_W-1:0] reset_note(input logic [SLOT_W-1:0] idx);
        logic [BYTE_W-1:0] n;
        case (idx)
            4'd0: n = 8'd36;
            4'd1: n = 8'd38;
            4'd2: n = 8'd47;
            4'd3: n = 8'd50;
            4'd4: n = 8'd43;
            4'd5: n = 8'd42;
            4'd6: n = 8'd46;
            4'd7: n = 8'd51;
            default: n = NOTE_NONE;
        endcase
        return n;
    endfunction

endpackage

/* design/mtsvm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies; used for both the slot state and the waveform store.
module mtsvm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/midi_triggered_sample_voice_mixer_top.sv */
// A frame tick goes from its input beat through the read state, then the evaluate and multiply
// states for each slot (one slot-memory read, one waveform read and one multiply per slot).
// A MIDI note-on walks every slot; write uses the write state, configure and trigger one slot.
// Throughput: one item at a time; the next beat is taken once the sequencer is back in idle,
// while a finished mix may still wait in the output register.
// Reset: synchronous, active low; clears slot valid bits, the output valid and the sequencer, no clearing pass.
module midi_triggered_sample_voice_mixer_top
    import mtsvm_pkg::*;
#(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int SLOT_DEPTH  = SLOT_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [OP_W-1:0]                        s_op,
    input  logic [BYTE_W-1:0]                      s_status_byte,
    input  logic [BYTE_W-1:0]                      s_data_one,
    input  logic [BYTE_W-1:0]                      s_data_two,
    input  logic [SLOT_W-1:0]                      s_slot,
    input  logic [$clog2(SLOT_DEPTH)-1:0]          s_address,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample_value,
    input  logic [$clog2(SLOT_DEPTH+1)-1:0]        s_length_in,
    input  logic [BYTE_W-1:0]                      s_note_in,
    input  logic                                   s_active_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [MIX_W-1:0]                m_mix
);

    // Derived sizes. Positions index one slot's waveform; lengths can reach the full depth.
    localparam int POS_W      = $clog2(SLOT_DEPTH);
    localparam int LEN_W      = $clog2(SLOT_DEPTH + 1);
    localparam int SLOT_IW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WAVE_DEPTH = NUM_SLOTS * SLOT_DEPTH;
    localparam int WA_W       = $clog2(WAVE_DEPTH);
    localparam int PROD_W     = SAMPLE_BITS + VEL_W + 1;
    localparam int SCL_W      = PROD_W - VEL_W;
    localparam int SUM_W      = (SCL_W > MIX_W) ? SCL_W : MIX_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_WR   = 3'd5;

    // One slot's state word as it sits in the slot memory.
    typedef struct packed {
        logic [1:0]        vstate;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] note;
        logic              active;
        logic [VEL_W-1:0]  vel;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    // Control registers.
    logic [2:0]           state_reg,   state_next;
    logic [NUM_SLOTS-1:0] valid_reg,   valid_next;
    logic                 m_valid_reg, m_valid_next;

    // Item and datapath registers; none of these needs a reset.
    logic [OP_W-1:0]           op_reg,       op_next;
    logic [SLOT_IW-1:0]        idx_reg,      idx_next;
    logic [BYTE_W-1:0]         key_reg,      key_next;
    logic [VEL_W-1:0]          vel_in_reg,   vel_in_next;
    logic [POS_W-1:0]          addr_reg,     addr_next;
    logic [SAMPLE_BITS-1:0]    sample_reg,   sample_next;
    logic [LEN_W-1:0]          len_reg,      len_next;
    logic [BYTE_W-1:0]         cfg_note_reg, cfg_note_next;
    logic                      cfg_act_reg,  cfg_act_next;
    logic [WA_W-1:0]           base_reg,     base_next;
    logic                      snd_reg,      snd_next;
    logic [VEL_W-1:0]          vel_reg,      vel_next;
    logic signed [PROD_W-1:0]  prod_reg,     prod_next;
    logic [MIX_W-1:0]          acc_reg,      acc_next;
    logic [MIX_W-1:0]          m_mix_reg,    m_mix_next;

    // Memory ports.
    logic                 slot_we;
    logic [SLOT_IW-1:0]   slot_raddr;
    entry_t               slot_wdata;
    logic [ENT_W-1:0]     slot_q;
    logic                 wave_we;
    logic [WA_W-1:0]      wave_waddr;
    logic [WA_W-1:0]      wave_raddr;
    logic [SAMPLE_BITS-1:0] wave_q;

    // Slot state after read, with never-written slots showing their reset contents.
    entry_t               cur;
    entry_t               rst_entry;
    logic                 last;

    // Frame evaluation of the current slot.
    logic                 is_trig;
    logic                 is_stopped;
    logic                 len_zero;
    logic                 sounding;
    logic [POS_W-1:0]     start_pos;
    logic [LEN_W-1:0]     pos_inc;
    logic                 ends;
    entry_t               tick_entry;

    // Other operations on the current slot.
    logic                 note_match;
    entry_t               midi_entry;
    entry_t               cfg_entry;
    entry_t               trig_entry;

    // Accept-time decode of the input beat.
    logic                 accept;
    logic                 slot_ok;
    logic                 addr_ok;
    logic                 note_on;
    logic [LEN_W-1:0]     len_sat;

    // Voice scaling: floor((sample * velocity) / 128), carried modulo 2^20 into the mix.
    logic signed [PROD_W-1:0] product;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  scaled_ext;
    logic [MIX_W-1:0]         scaled_mix;

    mtsvm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (slot_we),
        .waddr (idx_reg),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_q)
    );

    mtsvm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WAVE_DEPTH)
    ) u_wave_ram (
        .clk   (aclk),
        .we    (wave_we),
        .waddr (wave_waddr),
        .wdata (sample_reg),
        .raddr (wave_raddr),
        .rdata (wave_q)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_mix   = m_mix_reg;

    // Input decode. Writes, configures and triggers to a slot that does not exist are dropped,
    // and a MIDI message other than a note-on with nonzero velocity needs no slot pass at all.
    assign slot_ok = {1'b0, s_slot} < (SLOT_W + 1)'(NUM_SLOTS);
    assign addr_ok = LEN_W'(s_address) < LEN_W'(SLOT_DEPTH);
    assign note_on = (s_status_byte[7:4] == MIDI_NOTE_ON) && (s_data_two != '0);
    assign len_sat = (s_length_in > LEN_W'(SLOT_DEPTH)) ? LEN_W'(SLOT_DEPTH) : s_length_in;

    assign last = (idx_reg == SLOT_IW'(NUM_SLOTS - 1));

    // The slot memory is read ahead of use: in the read state for the addressed slot, and while
    // walking the slots for the next one (the write back goes to the current one, so the two
    // accesses meet on the same entry only at the last slot, where the read address holds).
    assign slot_raddr = (state_reg == ST_RD || last) ? idx_reg : idx_reg + 1'b1;

    always_comb begin
        rst_entry        = '0;
        rst_entry.vstate = VS_STOPPED;
        rst_entry.note   = reset_note(SLOT_W'(idx_reg));
        rst_entry.vel    = VEL_RESET;
        cur = valid_reg[idx_reg] ? entry_t'(slot_q) : rst_entry;
    end

    // Frame tick on one slot. A triggered slot restarts at position zero, or stops silently if
    // it has no length. A position stored for a playing slot is always below the length, so it is
    // inside the slot's waveform and every sounding voice reads a sample.
    always_comb begin
        is_trig    = (cur.vstate == VS_TRIGGERED);
        is_stopped = (cur.vstate == VS_STOPPED);
        len_zero   = (cur.len == '0);
        sounding   = !is_stopped && !(is_trig && len_zero);
        start_pos  = is_trig ? '0 : cur.pos;
        pos_inc    = LEN_W'(start_pos) + 1'b1;
        ends       = (pos_inc >= cur.len);
        tick_entry = cur;
        if (is_trig && len_zero) begin
            tick_entry.vstate = VS_STOPPED;
        end else if (!is_stopped) begin
            tick_entry.vstate = ends ? VS_STOPPED : VS_PLAYING;
            tick_entry.pos    = ends ? '0 : pos_inc[POS_W-1:0];
        end
    end

    // Note-on, configure and trigger on one slot.
    always_comb begin
        note_match = cur.active && (cur.note < NOTE_NONE) && (cur.note == key_reg);

        midi_entry        = cur;
        midi_entry.vstate = VS_TRIGGERED;
        midi_entry.vel    = vel_in_reg;

        cfg_entry        = cur;
        cfg_entry.vstate = VS_STOPPED;
        cfg_entry.pos    = '0;
        cfg_entry.len    = len_reg;
        cfg_entry.note   = cfg_note_reg;
        cfg_entry.active = cfg_act_reg && (len_reg != '0);

        trig_entry        = cur;
        trig_entry.vstate = VS_TRIGGERED;
        trig_entry.active = 1'b1;
    end

    always_comb begin
        product    = $signed(wave_q) * $signed({1'b0, vel_reg});
        scaled     = prod_reg[PROD_W-1:VEL_W];
        scaled_ext = SUM_W'(scaled);
        scaled_mix = scaled_ext[MIX_W-1:0];
    end

    assign wave_raddr = base_reg + WA_W'(start_pos);
    assign wave_waddr = WA_W'(idx_reg) * WA_W'(SLOT_DEPTH) + WA_W'(addr_reg);

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        vel_in_next   = vel_in_reg;
        addr_next     = addr_reg;
        sample_next   = sample_reg;
        len_next      = len_reg;
        cfg_note_next = cfg_note_reg;
        cfg_act_next  = cfg_act_reg;
        base_next     = base_reg;
        snd_next      = snd_reg;
        vel_next      = vel_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        m_mix_next    = m_mix_reg;
        slot_we       = 1'b0;
        slot_wdata    = cur;
        wave_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next       = s_op;
                    key_next      = s_data_one;
                    vel_in_next   = s_data_two[7] ? VEL_MAX : s_data_two[VEL_W-1:0];
                    addr_next     = s_address;
                    sample_next   = s_sample_value;
                    len_next      = len_sat;
                    cfg_note_next = s_note_in;
                    cfg_act_next  = s_active_in;
                    idx_next      = s_slot[SLOT_IW-1:0];
                    base_next     = '0;
                    prod_next     = '0;
                    acc_next      = '0;
                    case (s_op)
                        OP_TICK: begin
                            idx_next   = '0;
                            state_next = ST_RD;
                        end
                        OP_MIDI: begin
                            idx_next   = '0;
                            state_next = note_on ? ST_RD : ST_IDLE;
                        end
                        OP_WRITE: begin
                            state_next = (slot_ok && addr_ok) ? ST_WR : ST_IDLE;
                        end
                        OP_CONFIG, OP_TRIGGER: begin
                            state_next = slot_ok ? ST_RD : ST_IDLE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WR: begin
                wave_we    = 1'b1;
                state_next = ST_IDLE;
            end

            ST_RD: begin
                state_next = ST_EVAL;
            end

            ST_EVAL: begin
                case (op_reg)
                    OP_TICK: begin
                        // The previous slot's product lands in the mix while this slot's
                        // sample is being fetched.
                        slot_we    = !is_stopped;
                        slot_wdata = tick_entry;
                        snd_next   = sounding;
                        vel_next   = cur.vel;
                        acc_next   = acc_reg + scaled_mix;
                        state_next = ST_MUL;
                    end
                    OP_MIDI: begin
                        slot_we    = note_match;
                        slot_wdata = midi_entry;
                        if (last) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    OP_CONFIG: begin
                        slot_we    = 1'b1;
                        slot_wdata = cfg_entry;
                        state_next = ST_IDLE;
                    end
                    OP_TRIGGER: begin
                        slot_we    = is_stopped;
                        slot_wdata = trig_entry;
                        state_next = ST_IDLE;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_MUL: begin
                prod_next = snd_reg ? product : '0;
                if (last) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    base_next  = base_reg + WA_W'(SLOT_DEPTH);
                    state_next = ST_EVAL;
                end
            end

            ST_DONE: begin
                // Holds here only while an earlier mix still waits to be taken.
                if (!m_valid_reg || m_ready) begin
                    m_mix_next   = acc_reg + scaled_mix;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (slot_we) begin
            valid_next[idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        vel_in_reg   <= vel_in_next;
        addr_reg     <= addr_next;
        sample_reg   <= sample_next;
        len_reg      <= len_next;
        cfg_note_reg <= cfg_note_next;
        cfg_act_reg  <= cfg_act_next;
        base_reg     <= base_next;
        snd_reg      <= snd_next;
        vel_reg      <= vel_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        m_mix_reg    <= m_mix_next;
    end

    // A slot written back as playing must still have samples left to play.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_we && slot_wdata.vstate == VS_PLAYING) |->
            (LEN_W'(slot_wdata.pos) < slot_wdata.len))
        else $error("playing slot written back with position at or past its length");

    // The slot walk never leaves the populated slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (idx_reg <= SLOT_IW'(NUM_SLOTS - 1)))
        else $error("slot index out of range during a pass");

    // A new mix beat appears only as the close of a frame pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat raised outside the end of a frame pass");

endmodule
